/* rtl/tcbid_pkg.sv */
// ----------------------------------------------------------------------------
// tcbid_pkg: shared definitions for the two-channel burst interval detector
// Register indexes, reset levels and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package tcbid_pkg;

  // Default widths for the top-level parameters.
  localparam int SampleBitsDef = 16;
  localparam int IndexBitsDef  = 32;

  // Reported intervals and periods are always this wide.
  localparam int OutBits = 32;

  // Configuration port.
  localparam int CfgIdxBits  = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PD_THRESHOLD_HIGH = 2'd0,
    CFG_PD_THRESHOLD_LOW  = 2'd1,
    CFG_LP_THRESHOLD_HIGH = 2'd2
  } cfg_reg_e;

  // Reset levels, cut down to the sample width at the point of use.
  localparam logic [31:0] PdThresholdHighRst = 32'd16384;
  localparam logic [31:0] PdThresholdLowRst  = 32'd8192;
  localparam logic [31:0] LpThresholdHighRst = 32'd16384;

endpackage

/* rtl/tcbid_in_if.sv */
// ----------------------------------------------------------------------------
// tcbid_in_if: sample pair channel
// Carries one PD/LP sample pair and its running sample index per word.
// ----------------------------------------------------------------------------
interface tcbid_in_if #(
  parameter int SAMPLE_BITS = tcbid_pkg::SampleBitsDef,
  parameter int INDEX_BITS  = tcbid_pkg::IndexBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_pd;
  logic signed [SAMPLE_BITS-1:0] sample_lp;
  logic        [INDEX_BITS-1:0]  sample_index;

  modport source (output valid, sample_pd, sample_lp, sample_index, input ready);
  modport sink   (input valid, sample_pd, sample_lp, sample_index, output ready);
endinterface

/* rtl/tcbid_out_if.sv */
// ----------------------------------------------------------------------------
// tcbid_out_if: detection result channel
// Carries burst-start flags, the LP-to-PD interval and the LP period per word.
// ----------------------------------------------------------------------------
interface tcbid_out_if;
  logic                             valid;
  logic                             ready;
  logic                             pd_burst_start;
  logic                             lp_burst_start;
  logic [tcbid_pkg::OutBits-1:0]    lppd_interval;
  logic                             interval_valid;
  logic [tcbid_pkg::OutBits-1:0]    lp_period;
  logic                             period_valid;
  logic                             report_valid;

  modport source (output valid, pd_burst_start, lp_burst_start, lppd_interval,
                  interval_valid, lp_period, period_valid, report_valid,
                  input ready);
  modport sink   (input valid, pd_burst_start, lp_burst_start, lppd_interval,
                  interval_valid, lp_period, period_valid, report_valid,
                  output ready);
endinterface

/* rtl/two_channel_burst_interval_detector_core.sv */
// ----------------------------------------------------------------------------
// two_channel_burst_interval_detector_core: PD/LP burst interval detector
// Detects burst starts on two channels and reports the LP-to-PD interval.
// ----------------------------------------------------------------------------
// The block takes one sample pair word per clock cycle and returns exactly one
// result word for each, in order. A word passes through an input register and
// then a result register. The result word is offered once it has been loaded
// into the result register, which waits while it holds a word not yet taken.
// The sustained rate of the block is one word per clock cycle as long as
// the result side keeps taking words. The detector state (arm flags, last LP
// start index and last LP period) is updated in the same edge that loads the
// result register, so consecutive words see each other's effects without any
// bubble. The PD channel is evaluated first: a PD burst starts when PD is armed
// and its sample rises strictly above the high threshold; while disarmed, a
// sample strictly below the low threshold re-arms PD and also arms LP, which
// can then start an LP burst on the same sample. Intervals and periods are raw
// sample counts that wrap modulo 2^INDEX_BITS and are reported 32 bits wide.
// The user must write thresholds on the plain configuration port only while the
// block is idle; the block does not enforce it. Unused-index writes are ignored.
// ----------------------------------------------------------------------------
module two_channel_burst_interval_detector_core #(
  parameter int SAMPLE_BITS = tcbid_pkg::SampleBitsDef,
  parameter int INDEX_BITS  = tcbid_pkg::IndexBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [tcbid_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]           cfg_wdata_i,

  // Sample pair words in, result words out.
  tcbid_in_if.sink                         in_i,
  tcbid_out_if.source                      out_o
);

  localparam int OutBits = tcbid_pkg::OutBits;

  localparam logic [31:0] PdHiRst = tcbid_pkg::PdThresholdHighRst;
  localparam logic [31:0] PdLoRst = tcbid_pkg::PdThresholdLowRst;
  localparam logic [31:0] LpHiRst = tcbid_pkg::LpThresholdHighRst;

  // --------------------------------------------------------------------------
  // Threshold registers.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] pd_thr_hi_q;
  logic signed [SAMPLE_BITS-1:0] pd_thr_lo_q;
  logic signed [SAMPLE_BITS-1:0] lp_thr_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_thr_hi_q <= PdHiRst[SAMPLE_BITS-1:0];
      pd_thr_lo_q <= PdLoRst[SAMPLE_BITS-1:0];
      lp_thr_hi_q <= LpHiRst[SAMPLE_BITS-1:0];
    end else if (cfg_we_i) begin
      unique case (tcbid_pkg::cfg_reg_e'(cfg_idx_i))
        tcbid_pkg::CFG_PD_THRESHOLD_HIGH: pd_thr_hi_q <= cfg_wdata_i;
        tcbid_pkg::CFG_PD_THRESHOLD_LOW:  pd_thr_lo_q <= cfg_wdata_i;
        tcbid_pkg::CFG_LP_THRESHOLD_HIGH: lp_thr_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input stage moves on whenever the result register is empty
  // or its word is being taken in this cycle.
  // --------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic in_fire;
  logic stage_adv;

  assign stage_adv = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || stage_adv;
  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (stage_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register.
  logic signed [SAMPLE_BITS-1:0] pd_q;
  logic signed [SAMPLE_BITS-1:0] lp_q;
  logic        [INDEX_BITS-1:0]  idx_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pd_q  <= in_i.sample_pd;
      lp_q  <= in_i.sample_lp;
      idx_q <= in_i.sample_index;
    end
  end

  // --------------------------------------------------------------------------
  // Detector state.
  // --------------------------------------------------------------------------
  logic                  pd_armed_q, pd_armed_d;
  logic                  lp_armed_q, lp_armed_d;
  logic                  lp_seen_q, lp_seen_d;
  logic                  period_seen_q, period_seen_d;
  logic [INDEX_BITS-1:0] last_lp_start_q, last_lp_start_d;
  logic [INDEX_BITS-1:0] last_period_q, last_period_d;

  // Per-word decisions.
  logic                  pd_start;
  logic                  pd_rearm;
  logic                  lp_armed_mid;
  logic                  lp_start;
  logic                  interval_ok;
  logic                  report;
  logic [INDEX_BITS-1:0] idx_diff;
  logic [INDEX_BITS-1:0] interval;

  // Zero-extend or truncate index-wide values to the result width.
  logic [INDEX_BITS+OutBits-1:0] interval_ext;
  logic [INDEX_BITS+OutBits-1:0] period_ext;

  always_comb begin
    // Distance from the last LP start, shared by the interval and the period.
    idx_diff = idx_q - last_lp_start_q;

    // PD channel goes first.
    pd_start = (pd_q > pd_thr_hi_q) && pd_armed_q;
    pd_rearm = !pd_start && (pd_q < pd_thr_lo_q) && !pd_armed_q;

    pd_armed_d = pd_armed_q;
    if (pd_start) begin
      pd_armed_d = 1'b0;
    end else if (pd_rearm) begin
      pd_armed_d = 1'b1;
    end

    // A re-arm on this sample lets LP start on the same sample.
    lp_armed_mid = pd_rearm || lp_armed_q;
    lp_start     = (lp_q > lp_thr_hi_q) && lp_armed_mid;
    lp_armed_d   = lp_armed_mid && !lp_start;

    // The interval and report use the LP history from earlier samples only.
    interval_ok = pd_start && lp_seen_q;
    interval    = interval_ok ? idx_diff : '0;
    report      = interval_ok && period_seen_q;

    last_lp_start_d = last_lp_start_q;
    lp_seen_d       = lp_seen_q;
    last_period_d   = last_period_q;
    period_seen_d   = period_seen_q;
    if (lp_start) begin
      if (lp_seen_q) begin
        last_period_d = idx_diff;
        period_seen_d = 1'b1;
      end
      last_lp_start_d = idx_q;
      lp_seen_d       = 1'b1;
    end

    interval_ext = {{OutBits{1'b0}}, interval};
    period_ext   = {{OutBits{1'b0}}, last_period_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_armed_q      <= 1'b0;
      lp_armed_q      <= 1'b0;
      lp_seen_q       <= 1'b0;
      period_seen_q   <= 1'b0;
      last_lp_start_q <= '0;
      last_period_q   <= '0;
    end else if (stage_adv) begin
      pd_armed_q      <= pd_armed_d;
      lp_armed_q      <= lp_armed_d;
      lp_seen_q       <= lp_seen_d;
      period_seen_q   <= period_seen_d;
      last_lp_start_q <= last_lp_start_d;
      last_period_q   <= last_period_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic               res_pd_start_q;
  logic               res_lp_start_q;
  logic [OutBits-1:0] res_interval_q;
  logic               res_interval_ok_q;
  logic [OutBits-1:0] res_period_q;
  logic               res_period_ok_q;
  logic               res_report_q;

  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      res_pd_start_q    <= pd_start;
      res_lp_start_q    <= lp_start;
      res_interval_q    <= interval_ext[OutBits-1:0];
      res_interval_ok_q <= interval_ok;
      res_period_q      <= period_ext[OutBits-1:0];
      res_period_ok_q   <= period_seen_d;
      res_report_q      <= report;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pd_burst_start = res_pd_start_q;
  assign out_o.lp_burst_start = res_lp_start_q;
  assign out_o.lppd_interval  = res_interval_q;
  assign out_o.interval_valid = res_interval_ok_q;
  assign out_o.lp_period      = res_period_q;
  assign out_o.period_valid   = res_period_ok_q;
  assign out_o.report_valid   = res_report_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-channel burst interval detector
// Drives sample pair words through a table of directed cases and then several
// threshold settings with random words, and checks every result word against the
// typed-in result or a predictor of PD/LP hysteresis, LP period, LP-to-PD interval.
// ----------------------------------------------------------------------------
module testbench;

  // Sample pair word as it crosses the input channel.
  typedef struct packed {
    logic signed [15:0] pd;
    logic signed [15:0] lp;
    logic [31:0]        idx;
  } sample_word_t;

  // Result word, one per sample pair word.
  typedef struct packed {
    logic        pd_start;
    logic        lp_start;
    logic [31:0] interval;
    logic        interval_valid;
    logic [31:0] period;
    logic        period_valid;
    logic        report;
  } burst_report_t;

  // A directed case: the word, and a typed-in result where one is given.
  typedef struct packed {
    sample_word_t  word;
    logic          typed;
    burst_report_t want;
  } directed_row_t;

  // How a random phase picks its thresholds.
  typedef enum logic [1:0] {
    THR_FIXED,
    THR_ORDERED,
    THR_ANY
  } thr_kind_e;

  typedef struct packed {
    thr_kind_e   kind;
    logic [15:0] pd_high;
    logic [15:0] pd_low;
    logic [15:0] lp_high;
    logic [15:0] words;
    logic        quiet;
    logic        near_wrap;
  } phase_t;

  localparam logic signed [15:0] SampleMax = 16'sh7fff;
  localparam logic signed [15:0] SampleMin = 16'sh8000;

  // Index 3 of the configuration port maps to no register.
  localparam logic [tcbid_pkg::CfgIdxBits-1:0] CfgIdxUnused = 2'd3;

  localparam int DirectedRows = 18;
  localparam int Phases       = 6;
  localparam int HoldCycles   = 48;

  // The first rows run with the reset thresholds: PD high 16384, PD low 8192,
  // LP high 16384. Rows with a typed-in result cover the start after reset,
  // equal levels, the re-arm that lets LP start on the same word, index
  // wrapping and indices that go backwards; the rest go to the predictor.
  localparam directed_row_t DIRECTED[DirectedRows] = '{
    // Both channels disarmed after reset: full-scale samples do nothing.
    '{'{SampleMax, SampleMax, 32'd0}, 1'b1, '{0, 0, 32'd0, 0, 32'd0, 0, 0}},
    // PD exactly at its low threshold does not re-arm.
    '{'{16'sd8192, SampleMax, 32'd1}, 1'b1, '{0, 0, 32'd0, 0, 32'd0, 0, 0}},
    // Re-arm of both channels; LP exactly at its threshold does not start.
    '{'{SampleMin, 16'sd16384, 32'd2}, 1'b1, '{0, 0, 32'd0, 0, 32'd0, 0, 0}},
    // PD at its high threshold stays put; first LP start, no period yet.
    '{'{16'sd16384, 16'sd16385, 32'd5}, 1'b1, '{0, 1, 32'd0, 0, 32'd0, 0, 0}},
    // PD start with an interval but no period, so no report.
    '{'{SampleMax, SampleMax, 32'd12}, 1'b1, '{1, 0, 32'd7, 1, 32'd0, 0, 0}},
    // Re-arm and LP start on the same word: the first period.
    '{'{SampleMin, SampleMax, 32'd20}, 1'b1, '{0, 1, 32'd0, 0, 32'd15, 1, 0}},
    // First full report.
    '{'{SampleMax, SampleMin, 32'd26}, 1'b1, '{1, 0, 32'd6, 1, 32'd15, 1, 1}},
    // LP start at the top index.
    '{'{SampleMin, SampleMax, 32'hffff_ffff}, 1'b1,
      '{0, 1, 32'd0, 0, 32'hffff_ffeb, 1, 0}},
    // The interval wraps past zero.
    '{'{SampleMax, 16'sd0, 32'd3}, 1'b1, '{1, 0, 32'd4, 1, 32'hffff_ffeb, 1, 1}},
    // Index goes backwards; the period wraps.
    '{'{16'sd0, SampleMax, 32'd1}, 1'b1, '{0, 1, 32'd0, 0, 32'd2, 1, 0}},
    '{'{SampleMax, SampleMax, 32'd0}, 1'b1,
      '{1, 0, 32'hffff_ffff, 1, 32'd2, 1, 1}},
    '{'{-16'sd1, -16'sd1, 32'd100}, 1'b1, '{0, 0, 32'd0, 0, 32'd2, 1, 0}},
    // PD and LP start together: PD reports the older LP start.
    '{'{SampleMax, SampleMax, 32'd110}, 1'b1,
      '{1, 1, 32'd109, 1, 32'd109, 1, 1}},
    '{'{16'sd16385, -16'sd16384, 32'd111}, 1'b0, '0},
    '{'{16'sd8191, 16'sd16385, 32'd120}, 1'b0, '0},
    '{'{16'sd16385, 16'sd0, 32'd121}, 1'b0, '0},
    '{'{16'sd8191, 16'sd0, 32'd122}, 1'b0, '0},
    '{'{16'sd16384, 16'sd16384, 32'd123}, 1'b0, '0}
  };

  // Random phases. The first two put the thresholds at the extremes: nothing
  // can start, then everything starts as often as the hysteresis allows.
  localparam phase_t PHASES[Phases] = '{
    '{THR_FIXED,   16'h7fff, 16'h8000, 16'h7fff, 16'd30,  1'b0, 1'b0},
    '{THR_FIXED,   16'h8000, 16'h7fff, 16'h8000, 16'd60,  1'b0, 1'b0},
    '{THR_FIXED,   16'd1000, 16'hfc18, 16'd0,    16'd150, 1'b1, 1'b0},
    '{THR_ORDERED, 16'd0,    16'd0,    16'd0,    16'd120, 1'b0, 1'b0},
    '{THR_FIXED,   16'd16384, 16'd8192, 16'd16384, 16'd120, 1'b0, 1'b1},
    '{THR_ANY,     16'd0,    16'd0,    16'd0,    16'd70,  1'b0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                             cfg_we_i;
  logic [tcbid_pkg::CfgIdxBits-1:0] cfg_idx_i;
  logic [15:0]                      cfg_wdata_i;

  tcbid_in_if #(
    .SAMPLE_BITS(tcbid_pkg::SampleBitsDef),
    .INDEX_BITS (tcbid_pkg::IndexBitsDef)
  ) in_if ();
  tcbid_out_if out_if ();

  two_channel_burst_interval_detector_core #(
    .SAMPLE_BITS(tcbid_pkg::SampleBitsDef),
    .INDEX_BITS (tcbid_pkg::IndexBitsDef)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Thresholds as the predictor sees them, tracking every register write.
  logic signed [15:0] thr_pd_high = 16'sd16384;
  logic signed [15:0] thr_pd_low  = 16'sd8192;
  logic signed [15:0] thr_lp_high = 16'sd16384;

  // Detector state of the predictor, all clear after reset.
  logic        pd_armed      = 1'b0;
  logic        lp_armed      = 1'b0;
  logic [31:0] last_lp_start = '0;
  logic        lp_seen       = 1'b0;
  logic [31:0] last_period   = '0;
  logic        period_seen   = 1'b0;

  // Result words still owed by the block, oldest first.
  burst_report_t reports_due[$];
  int            fail_count = 0;

  // When set, both sides idle and stall at random; cleared for a quiet phase.
  bit idle_on = 1'b1;

  // Works out the result word for one accepted sample pair word and advances
  // the predictor state. PD is decided before LP, so a re-arm on this word can
  // let LP start on the same word, and a PD start reports the LP start of an
  // earlier word. All comparisons are strict; index differences wrap.
  function automatic burst_report_t detect_bursts(input sample_word_t w);
    burst_report_t r;
    r = '0;
    if ($signed(w.pd) > thr_pd_high && pd_armed) begin
      pd_armed   = 1'b0;
      r.pd_start = 1'b1;
      if (lp_seen) begin
        r.interval       = w.idx - last_lp_start;
        r.interval_valid = 1'b1;
        r.report         = period_seen;
      end
    end else if ($signed(w.pd) < thr_pd_low && !pd_armed) begin
      pd_armed = 1'b1;
      lp_armed = 1'b1;
    end
    if ($signed(w.lp) > thr_lp_high && lp_armed) begin
      lp_armed = 1'b0;
      if (lp_seen) begin
        last_period = w.idx - last_lp_start;
        period_seen = 1'b1;
      end
      last_lp_start = w.idx;
      lp_seen       = 1'b1;
      r.lp_start    = 1'b1;
    end
    // The period reported is the newest, including one measured just now.
    r.period       = last_period;
    r.period_valid = period_seen;
    return r;
  endfunction

  // Picks a sample level around a channel's thresholds, so that bursts start
  // and end often, with equal levels and full-scale noise mixed in.
  function automatic int pick_level(input int high, input int low);
    int mode;
    int v;
    mode = $urandom_range(0, 99);
    if (mode < 25) begin
      v = high + 1 + int'($urandom_range(0, 200));
    end else if (mode < 50) begin
      v = low - 1 - int'($urandom_range(0, 200));
    end else if (mode < 60) begin
      v = ($urandom_range(0, 1) == 0) ? high : low;
    end else if (mode < 75 && high > low) begin
      v = low + int'($urandom_range(0, high - low));
    end else begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Offers one word and returns at the edge where it is accepted. The valid
  // line stays high after acceptance so back-to-back words need no toggle.
  task automatic send_word(input sample_word_t w);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(0, 99) < 29) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_pd    <= w.pd;
    in_if.sample_lp    <= w.lp;
    in_if.sample_index <= w.idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Lowers valid and waits until every owed result word has come back, so the
  // two-stage pipeline is empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tcbid_pkg::CfgIdxBits-1:0] idx,
                           input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Writes all three thresholds and then a junk word to the unused index,
  // which the block must ignore. Only called while the block is idle.
  task automatic set_thresholds(input logic [15:0] pd_high, input logic [15:0] pd_low,
                                input logic [15:0] lp_high);
    write_reg(tcbid_pkg::CFG_PD_THRESHOLD_HIGH, pd_high);
    write_reg(tcbid_pkg::CFG_PD_THRESHOLD_LOW, pd_low);
    write_reg(tcbid_pkg::CFG_LP_THRESHOLD_HIGH, lp_high);
    write_reg(CfgIdxUnused, 16'($urandom()));
    cfg_we_i    <= 1'b0;
    thr_pd_high = pd_high;
    thr_pd_low  = pd_low;
    thr_lp_high = lp_high;
  endtask

  // Main stimulus: reset, the directed rows, then the random phases.
  initial begin
    sample_word_t  w;
    burst_report_t predicted;
    phase_t        ph;
    logic [15:0]   new_pd_high;
    logic [15:0]   new_pd_low;
    logic [15:0]   new_lp_high;
    logic [31:0]   next_idx;
    int            pick;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= tcbid_pkg::CFG_PD_THRESHOLD_HIGH;
    cfg_wdata_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.sample_pd    <= '0;
    in_if.sample_lp    <= '0;
    in_if.sample_index <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed rows still run the predictor so its state follows along.
    for (int i = 0; i < DirectedRows; i++) begin
      send_word(DIRECTED[i].word);
      predicted = detect_bursts(DIRECTED[i].word);
      reports_due.push_back(DIRECTED[i].typed ? DIRECTED[i].want : predicted);
    end

    next_idx = 32'd200;
    for (int p = 0; p < Phases; p++) begin
      ph = PHASES[p];
      settle();
      case (ph.kind)
        THR_ORDERED: begin
          new_pd_low  = 16'(int'($urandom_range(0, 30000)) - 20000);
          new_pd_high = new_pd_low + 16'($urandom_range(0, 15000));
          new_lp_high = 16'(int'($urandom_range(0, 40000)) - 20000);
        end
        THR_ANY: begin
          new_pd_high = 16'($urandom());
          new_pd_low  = 16'($urandom());
          new_lp_high = 16'($urandom());
        end
        default: begin
          new_pd_high = ph.pd_high;
          new_pd_low  = ph.pd_low;
          new_lp_high = ph.lp_high;
        end
      endcase
      set_thresholds(new_pd_high, new_pd_low, new_lp_high);
      idle_on = !ph.quiet;
      if (ph.near_wrap) next_idx = 32'hffff_ff80;

      for (int n = 0; n < int'(ph.words); n++) begin
        w.pd = 16'(pick_level(int'(thr_pd_high), int'(thr_pd_low)));
        w.lp = 16'(pick_level(int'(thr_lp_high), int'(thr_lp_high)));
        // Mostly a running index; now and then a jump or a step back.
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          next_idx += $urandom_range(1, 6);
        end else if (pick < 95) begin
          next_idx = $urandom();
        end else begin
          next_idx -= $urandom_range(1, 50);
        end
        w.idx = next_idx;
        send_word(w);
        reports_due.push_back(detect_bursts(w));
      end
    end

    settle();
    idle_on = 1'b1;
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && reports_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: random stalls, plus long hold-offs while the sender keeps
  // offering words, so the pipeline fills and the block drops its ready.
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && idle_on && in_if.valid &&
          (holds_done == 0 || $urandom_range(0, 299) == 0)) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !idle_on || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted result word is compared with the oldest owed one.
  always @(posedge clk_i) begin
    burst_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (reports_due.size() == 0) begin
        $error("result word with no sample pair word outstanding");
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("pd_burst_start", 32'(want.pd_start), 32'(out_if.pd_burst_start));
        check_field("lp_burst_start", 32'(want.lp_start), 32'(out_if.lp_burst_start));
        check_field("lppd_interval", want.interval, out_if.lppd_interval);
        check_field("interval_valid", 32'(want.interval_valid),
                    32'(out_if.interval_valid));
        check_field("lp_period", want.period, out_if.lp_period);
        check_field("period_valid", 32'(want.period_valid), 32'(out_if.period_valid));
        check_field("report_valid", 32'(want.report), 32'(out_if.report_valid));
      end
    end
  end

  // Watchdog: far beyond the slowest correct run of about 600 words.
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
